/* rtl/csob_pkg.sv */
package csob_pkg;

  typedef enum logic [1:0] {
    SHAPE_COLOR  = 2'd0,
    SHAPE_MONO   = 2'd1,
    SHAPE_MASKED = 2'd2,
    SHAPE_NONE   = 2'd3
  } shape_e;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_BLEND = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    CFG_CURSOR_X       = 3'd0,
    CFG_CURSOR_Y       = 3'd1,
    CFG_CURSOR_VISIBLE = 3'd2,
    CFG_SHAPE_TYPE     = 3'd3,
    CFG_CURSOR_WIDTH   = 3'd4,
    CFG_CURSOR_HEIGHT  = 3'd5
  } cfg_reg_e;

  localparam int unsigned CoordInW = 13;
  localparam int unsigned PixelW   = 32;
  localparam int unsigned CfgDataW = 16;

  localparam logic [PixelW-1:0] MonoBlack = 32'hFF00_0000;
  localparam logic [PixelW-1:0] MonoWhite = 32'hFFFF_FFFF;
  localparam logic [PixelW-1:0] MonoClear = 32'h0000_0000;
  localparam logic [PixelW-1:0] MonoGrey  = 32'hFF80_8080;

  typedef struct packed {
    logic                action;
    logic [CoordInW-1:0] pixel_col;
    logic [CoordInW-1:0] pixel_row;
    logic [PixelW-1:0]   pixel_word;
  } in_beat_t;

  typedef struct packed {
    logic [PixelW-1:0] out_pixel;
    logic              covered;
  } out_beat_t;

  typedef struct packed {
    cfg_reg_e            index;
    logic [CfgDataW-1:0] value;
  } cfg_beat_t;

  // Convert a shape pixel into the BGRA form kept in the store.
  function automatic logic [PixelW-1:0] convert_load(shape_e shape, logic [PixelW-1:0] word);
    logic [PixelW-1:0] res;
    res = word;
    unique case (shape)
      SHAPE_COLOR, SHAPE_NONE: res = word;
      SHAPE_MASKED: res = {{8{|word[31:24]}}, word[23:0]};
      SHAPE_MONO: begin
        unique case (word[1:0])
          2'b00:   res = MonoBlack;
          2'b10:   res = MonoWhite;
          2'b01:   res = MonoClear;
          default: res = MonoGrey;
        endcase
      end
      default: res = word;
    endcase
    return res;
  endfunction

  // Round-half-up of n/255 for n up to 255*255: floor((n+127)/255) via shifts.
  function automatic logic [7:0] div255_round(logic [15:0] n);
    logic [16:0] x;
    logic [16:0] s;
    x = {1'b0, n} + 17'd127;
    s = x + 17'd1 + (x >> 8);
    return s[15:8];
  endfunction

endpackage

/* rtl/csob_stream_if.sv */
interface csob_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/csob_ram.sv */
module csob_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cursor_shape_overlay_blend_core.sv */
// Hardware cursor overlay with alpha blend.
// Channels: in_i carries load and blend beats, out_o carries one result beat
// per blend beat (loads give none), cfg_i writes the cursor registers and is
// always ready. Write configuration only while no beat is in flight.
// A load beat writes one converted pixel into the cursor store (a single
// CURSOR_SIZE x CURSOR_SIZE RAM). A blend beat looks up the cursor pixel
// under its frame position and mixes it into the frame pixel.
// Registers: stage 1, stage 2, stage 3 and the result register. Throughput:
// one beat per cycle while out_o is not stalled; the stages coordinate check,
// RAM read, channel multiply and rounding divide use one register stage each.
// Loads and blends reach the RAM in the same stage, in arrival order, so a
// blend always sees every load accepted before it.
// Stall: when a result waits on out_o and the sink is not ready, the whole
// pipeline holds and in_i.ready drops; nothing is lost or repeated.
// Reset: clears all valid bits and the registers (shape type none, cursor
// hidden). The cursor store is not cleared and holds nothing until loaded.
module cursor_shape_overlay_blend_core #(
  parameter int unsigned CURSOR_SIZE = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  csob_stream_if.sink   in_i,
  csob_stream_if.source out_o,
  csob_stream_if.sink   cfg_i
);

  localparam int unsigned CoordW = $clog2(CURSOR_SIZE);
  localparam int unsigned AddrW  = $clog2(CURSOR_SIZE * CURSOR_SIZE);
  localparam int unsigned DimW   = 9;
  localparam logic [DimW-1:0] SizeLim = DimW'(CURSOR_SIZE);

  // Configuration registers
  logic signed [13:0]  cur_x_q;
  logic signed [13:0]  cur_y_q;
  logic                visible_q;
  csob_pkg::shape_e    shape_q;
  logic [DimW-1:0]     width_q;
  logic [DimW-1:0]     height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      visible_q <= 1'b0;
      shape_q   <= csob_pkg::SHAPE_NONE;
      width_q   <= '0;
      height_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        csob_pkg::CFG_CURSOR_X:       cur_x_q   <= $signed(cfg_i.data.value[13:0]);
        csob_pkg::CFG_CURSOR_Y:       cur_y_q   <= $signed(cfg_i.data.value[13:0]);
        csob_pkg::CFG_CURSOR_VISIBLE: visible_q <= cfg_i.data.value[0];
        csob_pkg::CFG_SHAPE_TYPE:     shape_q   <= csob_pkg::shape_e'(cfg_i.data.value[1:0]);
        csob_pkg::CFG_CURSOR_WIDTH:   width_q   <= cfg_i.data.value[DimW-1:0];
        csob_pkg::CFG_CURSOR_HEIGHT:  height_q  <= cfg_i.data.value[DimW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a result waits on a stalled sink.
  logic adv;
  logic out_valid_q;
  csob_pkg::out_beat_t out_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 1: decode the beat, check the cursor rectangle, form the address.
  logic                        s1_blend_d;
  logic                        s1_hit_d;
  logic                        s1_we_d;
  logic [AddrW-1:0]            s1_addr_d;
  logic [csob_pkg::PixelW-1:0] s1_data_d;
  logic [DimW-1:0]             w_lim;
  logic [DimW-1:0]             h_lim;
  logic signed [14:0]          lc;
  logic signed [14:0]          lr;
  logic                        in_rect;
  logic                        load_ok;
  logic [CoordW-1:0]           col_idx;
  logic [CoordW-1:0]           row_idx;

  always_comb begin
    w_lim = (width_q > SizeLim) ? SizeLim : width_q;
    h_lim = (height_q > SizeLim) ? SizeLim : height_q;
    lc = $signed({2'b00, in_i.data.pixel_col}) - $signed({cur_x_q[13], cur_x_q});
    lr = $signed({2'b00, in_i.data.pixel_row}) - $signed({cur_y_q[13], cur_y_q});
    in_rect = !lc[14] && !lr[14]
           && (lc[13:0] < {5'b0, w_lim}) && (lr[13:0] < {5'b0, h_lim});
    load_ok = (shape_q != csob_pkg::SHAPE_NONE)
           && (in_i.data.pixel_col < csob_pkg::CoordInW'(CURSOR_SIZE))
           && (in_i.data.pixel_row < csob_pkg::CoordInW'(CURSOR_SIZE));
    s1_blend_d = (in_i.data.action == csob_pkg::ACT_BLEND);
    s1_hit_d   = s1_blend_d && visible_q && (w_lim != '0) && (h_lim != '0) && in_rect;
    s1_we_d    = !s1_blend_d && load_ok;
    if (s1_blend_d) begin
      col_idx   = lc[CoordW-1:0];
      row_idx   = lr[CoordW-1:0];
      s1_data_d = in_i.data.pixel_word;
    end else begin
      col_idx   = in_i.data.pixel_col[CoordW-1:0];
      row_idx   = in_i.data.pixel_row[CoordW-1:0];
      s1_data_d = csob_pkg::convert_load(shape_q, in_i.data.pixel_word);
    end
    s1_addr_d = AddrW'(row_idx) * AddrW'(CURSOR_SIZE) + AddrW'(col_idx);
  end

  logic                        s1_valid_q;
  logic                        s1_blend_q;
  logic                        s1_hit_q;
  logic                        s1_we_q;
  logic [AddrW-1:0]            s1_addr_q;
  logic [csob_pkg::PixelW-1:0] s1_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_blend_q <= s1_blend_d;
      s1_hit_q   <= s1_hit_d;
      s1_we_q    <= s1_we_d;
      s1_addr_q  <= s1_addr_d;
      s1_data_q  <= s1_data_d;
    end
  end

  // Stage 2: cursor store access. Loads write here, covered blends read here.
  logic                        ram_we;
  logic                        ram_re;
  logic [csob_pkg::PixelW-1:0] cur_pix;

  assign ram_we = adv && s1_valid_q && s1_we_q;
  assign ram_re = adv && s1_valid_q && s1_hit_q;

  csob_ram #(
    .Width (csob_pkg::PixelW),
    .Depth (CURSOR_SIZE * CURSOR_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_data_q),
    .re_i    (ram_re),
    .raddr_i (s1_addr_q),
    .rdata_o (cur_pix)
  );

  logic                        s2_valid_q;
  logic                        s2_hit_q;
  logic [csob_pkg::PixelW-1:0] s2_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_blend_q;   // drop loads, they give no result
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_hit_q  <= s1_hit_q;
      s2_word_q <= s1_data_q;
    end
  end

  // Stage 3: per-channel weighted sum c*a + d*(255-a).
  logic [7:0]  alpha;
  logic [7:0]  inv_alpha;
  logic [15:0] mix_d [3];

  assign alpha     = cur_pix[31:24];
  assign inv_alpha = 8'd255 - alpha;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mix_d[ch] = 16'(cur_pix[8*ch +: 8]) * 16'(alpha)
                + 16'(s2_word_q[8*ch +: 8]) * 16'(inv_alpha);
    end
  end

  logic                        s3_valid_q;
  logic                        s3_mix_q;
  logic [csob_pkg::PixelW-1:0] s3_word_q;
  logic [15:0]                 s3_sum_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Near-transparent cursor pixels leave the frame untouched.
      s3_mix_q  <= s2_hit_q && (alpha > 8'd1);
      s3_word_q <= s2_word_q;
      for (int ch = 0; ch < 3; ch++) begin
        s3_sum_q[ch] <= mix_d[ch];
      end
    end
  end

  // Stage 4: round-divide by 255 and register the result beat.
  csob_pkg::out_beat_t out_d;

  always_comb begin
    out_d.covered = s3_mix_q;
    if (s3_mix_q) begin
      out_d.out_pixel = {8'hFF,
                         csob_pkg::div255_round(s3_sum_q[2]),
                         csob_pkg::div255_round(s3_sum_q[1]),
                         csob_pkg::div255_round(s3_sum_q[0])};
    end else begin
      out_d.out_pixel = s3_word_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Checks
  a_ram_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store written and read in the same cycle");

  a_hit_is_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_hit_q) |-> s1_blend_q)
    else $error("load beat flagged as cursor hit");

  a_covered_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.covered) |-> (out_q.out_pixel[31:24] == 8'hFF))
    else $error("covered pixel without full alpha");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with an empty result register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && out_valid_q && !out_o.ready) |=> s3_valid_q)
    else $error("beat lost behind a stalled result");

endmodule

/* tb/tb.sv */
module tb;

  localparam int CursorSize     = 256;
  localparam int FrameMax       = 8191;
  localparam int ItemTarget     = 1300;
  localparam int CalmAfter      = 1100;
  localparam int WatchdogLimit  = 2000;
  localparam int DrainCycles    = 12;
  localparam int LongHoldCycles = 300;
  localparam int MaxReports     = 30;
  localparam int PixelW         = csob_pkg::PixelW;
  localparam int CfgDataW       = csob_pkg::CfgDataW;
  localparam int CoordInW       = csob_pkg::CoordInW;

  // Shadow of the overlay: cursor registers, shape store and the queue of
  // result beats still owed by the block.
  class overlay_tracker;
    logic [PixelW-1:0]   shape_ram [CursorSize*CursorSize];
    bit                  shape_loaded [CursorSize*CursorSize];
    int unsigned         loaded_idx [$];
    int                  org_x;
    int                  org_y;
    bit                  shown;
    csob_pkg::shape_e    shape;
    int                  wid;
    int                  hgt;
    csob_pkg::out_beat_t pixels_due [$];
    int unsigned         n_fail;
    int unsigned         n_blends;
    int unsigned         n_stores;
    int unsigned         n_covered;
    int unsigned         n_cfg;

    function new();
      org_x = 0;
      org_y = 0;
      shown = 1'b0;
      shape = csob_pkg::SHAPE_NONE;
      wid   = 0;
      hgt   = 0;
    endfunction

    function void note_cfg(csob_pkg::cfg_reg_e idx, logic [CfgDataW-1:0] v);
      n_cfg++;
      case (idx)
        csob_pkg::CFG_CURSOR_X:       org_x = $signed(v[13:0]);
        csob_pkg::CFG_CURSOR_Y:       org_y = $signed(v[13:0]);
        csob_pkg::CFG_CURSOR_VISIBLE: shown = v[0];
        csob_pkg::CFG_SHAPE_TYPE:     shape = csob_pkg::shape_e'(v[1:0]);
        csob_pkg::CFG_CURSOR_WIDTH:   wid = int'(v[8:0]);
        csob_pkg::CFG_CURSOR_HEIGHT:  hgt = int'(v[8:0]);
        default: ;
      endcase
    endfunction

    // Store index under a frame position, or -1 when the cursor misses it.
    function int cover_index(int col, int row);
      int w;
      int h;
      int lc;
      int lr;
      w  = (wid < CursorSize) ? wid : CursorSize;
      h  = (hgt < CursorSize) ? hgt : CursorSize;
      lc = col - org_x;
      lr = row - org_y;
      if (!shown || w == 0 || h == 0) return -1;
      if (lc < 0 || lr < 0 || lc >= w || lr >= h) return -1;
      return lr * CursorSize + lc;
    endfunction

    function bit safe_blend(int col, int row);
      int i;
      i = cover_index(col, row);
      return (i < 0) || shape_loaded[i];
    endfunction

    function logic [7:0] blend_channel(logic [7:0] c, logic [7:0] d, logic [7:0] a);
      int unsigned cu;
      int unsigned du;
      int unsigned au;
      int unsigned n;
      cu = c;
      du = d;
      au = a;
      n  = cu * au + du * (255 - au);
      return 8'((2 * n + 255) / 510);
    endfunction

    function logic [PixelW-1:0] stored_form(logic [PixelW-1:0] w);
      case (shape)
        csob_pkg::SHAPE_MASKED: return {((w[31:24] != 8'h00) ? 8'hFF : 8'h00), w[23:0]};
        csob_pkg::SHAPE_MONO: begin
          // bit0 is the AND mask, bit1 the XOR mask
          if (w[0]) return w[1] ? csob_pkg::MonoGrey : csob_pkg::MonoClear;
          return w[1] ? csob_pkg::MonoWhite : csob_pkg::MonoBlack;
        end
        default: return w;
      endcase
    endfunction

    function void note_beat(csob_pkg::in_beat_t b);
      int                  idx;
      logic [PixelW-1:0]   cur;
      csob_pkg::out_beat_t due;
      if (b.action == csob_pkg::ACT_LOAD) begin
        if (shape != csob_pkg::SHAPE_NONE && b.pixel_col < CursorSize &&
            b.pixel_row < CursorSize) begin
          idx = int'(b.pixel_row) * CursorSize + int'(b.pixel_col);
          shape_ram[idx]    = stored_form(b.pixel_word);
          shape_loaded[idx] = 1'b1;
          loaded_idx.insert(loaded_idx.size(), idx);
          n_stores++;
        end
        return;
      end
      n_blends++;
      due.out_pixel = b.pixel_word;
      due.covered   = 1'b0;
      idx = cover_index(int'(b.pixel_col), int'(b.pixel_row));
      if (idx >= 0) begin
        cur = shape_ram[idx];
        if (cur[31:24] > 8'd1) begin
          due.out_pixel = {8'hFF,
                           blend_channel(cur[23:16], b.pixel_word[23:16], cur[31:24]),
                           blend_channel(cur[15:8], b.pixel_word[15:8], cur[31:24]),
                           blend_channel(cur[7:0], b.pixel_word[7:0], cur[31:24])};
          due.covered = 1'b1;
          n_covered++;
        end
      end
      pixels_due.insert(pixels_due.size(), due);
    endfunction

    function void flag(string what, logic [PixelW-1:0] want, logic [PixelW-1:0] got);
      n_fail++;
      if (n_fail <= MaxReports)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    function void check_pixel(csob_pkg::out_beat_t got);
      csob_pkg::out_beat_t want;
      if (pixels_due.size() == 0) begin
        n_fail++;
        if (n_fail <= MaxReports)
          $display("%0t: result beat with nothing expected, expected none, actual %h/%b",
                   $time, got.out_pixel, got.covered);
        return;
      end
      want = pixels_due.pop_front();
      if (got.out_pixel !== want.out_pixel) flag("out_pixel", want.out_pixel, got.out_pixel);
      if (got.covered !== want.covered) flag("covered", PixelW'(want.covered), PixelW'(got.covered));
    endfunction

    function int unsigned pending();
      return pixels_due.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  csob_stream_if #(.payload_t(csob_pkg::in_beat_t))  in_if ();
  csob_stream_if #(.payload_t(csob_pkg::out_beat_t)) out_if ();
  csob_stream_if #(.payload_t(csob_pkg::cfg_beat_t)) cfg_if ();

  overlay_tracker tracker = new();

  bit          idle_in_en   = 1'b1;
  bit          idle_out_en  = 1'b1;
  bit          hold_req     = 1'b0;
  int unsigned quiet_cycles = 0;

  cursor_shape_overlay_blend_core #(
    .CURSOR_SIZE(CursorSize)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Check every result beat against the oldest owed pixel.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) tracker.check_pixel(out_if.data);
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no beat moved for %0d cycles", $time, WatchdogLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result sink: random back-pressure bursts, plus one long hold-off on request
  // so that the pipeline fills and the block has to stall its input.
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_out_en && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  function automatic csob_pkg::in_beat_t make_beat(csob_pkg::action_e act, int col, int row,
                                                   logic [PixelW-1:0] word);
    csob_pkg::in_beat_t b;
    b.action     = act;
    b.pixel_col  = CoordInW'(col);
    b.pixel_row  = CoordInW'(row);
    b.pixel_word = word;
    return b;
  endfunction

  // Shape pixel with alpha pushed toward the interesting values now and then.
  function automatic logic [PixelW-1:0] shape_word();
    logic [PixelW-1:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0: w[31:24] = 8'h00;
      1: w[31:24] = 8'h01;
      2: w[31:24] = 8'h02;
      3: w[31:24] = 8'hFE;
      4: w[31:24] = 8'hFF;
      default: ;
    endcase
    return w;
  endfunction

  // Pick a frame pixel: mostly on loaded cursor pixels or around the cursor
  // edges, sometimes anywhere. Never land on a store entry not yet loaded.
  function automatic csob_pkg::in_beat_t pick_blend();
    int          col;
    int          row;
    int          ew;
    int          eh;
    int unsigned idx;
    int unsigned sel;
    int unsigned tries;
    bit          ok;
    ew  = (tracker.wid < CursorSize) ? tracker.wid : CursorSize;
    eh  = (tracker.hgt < CursorSize) ? tracker.hgt : CursorSize;
    sel = $urandom_range(0, 3);
    ok  = 1'b0;
    col = 0;
    row = 0;
    for (tries = 0; tries < 20 && !ok && sel != 3; tries++) begin
      if (sel <= 1 && tracker.loaded_idx.size() != 0) begin
        idx = tracker.loaded_idx[$urandom_range(0, tracker.loaded_idx.size() - 1)];
        col = tracker.org_x + int'(idx % CursorSize);
        row = tracker.org_y + int'(idx / CursorSize);
      end else begin
        col = tracker.org_x + int'($urandom_range(0, ew + 3)) - 2;
        row = tracker.org_y + int'($urandom_range(0, eh + 3)) - 2;
      end
      ok = col >= 0 && col <= FrameMax && row >= 0 && row <= FrameMax &&
           tracker.safe_blend(col, row);
    end
    while (!ok) begin
      col = int'($urandom_range(0, FrameMax));
      row = int'($urandom_range(0, FrameMax));
      ok  = tracker.safe_blend(col, row);
    end
    return make_beat(csob_pkg::ACT_BLEND, col, row, $urandom());
  endfunction

  // Offer one input beat, hold it until accepted, then record it.
  task automatic offer_beat(csob_pkg::in_beat_t b);
    if (idle_in_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tracker.note_beat(b);
  endtask

  task automatic write_reg(csob_pkg::cfg_reg_e idx, logic [CfgDataW-1:0] v);
    csob_pkg::cfg_beat_t c;
    c.index = idx;
    c.value = v;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    tracker.note_cfg(idx, v);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every owed result is back, then let trailing loads drain.
  task automatic settle();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic setup_cursor(int x, int y, bit vis, csob_pkg::shape_e sh, int w, int h);
    settle();
    write_reg(csob_pkg::CFG_CURSOR_X, CfgDataW'(x));
    write_reg(csob_pkg::CFG_CURSOR_Y, CfgDataW'(y));
    write_reg(csob_pkg::CFG_CURSOR_VISIBLE, CfgDataW'(vis));
    write_reg(csob_pkg::CFG_SHAPE_TYPE, CfgDataW'(sh));
    write_reg(csob_pkg::CFG_CURSOR_WIDTH, CfgDataW'(w));
    write_reg(csob_pkg::CFG_CURSOR_HEIGHT, CfgDataW'(h));
  endtask

  // One phase: load the cursor shape first, then a blend-heavy stream with
  // stray loads, some of them hit by the very next blend.
  task automatic run_phase(int unsigned n_items, bit with_hold);
    int                 ew;
    int                 eh;
    int                 c;
    int                 r;
    int                 col;
    int                 row;
    int unsigned        i;
    csob_pkg::in_beat_t b;
    csob_pkg::in_beat_t prev;
    ew = (tracker.wid < CursorSize) ? tracker.wid : CursorSize;
    eh = (tracker.hgt < CursorSize) ? tracker.hgt : CursorSize;
    if (tracker.shape != csob_pkg::SHAPE_NONE) begin
      if (ew * eh <= 64) begin
        for (r = 0; r < eh; r++)
          for (c = 0; c < ew; c++)
            offer_beat(make_beat(csob_pkg::ACT_LOAD, c, r, shape_word()));
      end else begin
        repeat (32)
          offer_beat(make_beat(csob_pkg::ACT_LOAD, int'($urandom_range(0, ew - 1)),
                               int'($urandom_range(0, eh - 1)), shape_word()));
      end
    end
    if (with_hold) hold_req = 1'b1;
    prev = make_beat(csob_pkg::ACT_BLEND, 0, 0, '0);
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        // stray load: inside or just past the cursor, or anywhere at all
        if ($urandom_range(0, 4) == 0) begin
          col = int'($urandom_range(0, FrameMax));
          row = int'($urandom_range(0, FrameMax));
        end else begin
          col = int'($urandom_range(0, ew + 1));
          row = int'($urandom_range(0, eh + 1));
        end
        b = make_beat(csob_pkg::ACT_LOAD, col, row, shape_word());
      end else begin
        b   = pick_blend();
        col = tracker.org_x + int'(prev.pixel_col);
        row = tracker.org_y + int'(prev.pixel_row);
        // read back the pixel that was just loaded, right behind the load
        if (prev.action == csob_pkg::ACT_LOAD && $urandom_range(0, 1) == 0 && col >= 0 &&
            col <= FrameMax && row >= 0 && row <= FrameMax && tracker.safe_blend(col, row))
          b = make_beat(csob_pkg::ACT_BLEND, col, row, $urandom());
      end
      offer_beat(b);
      prev = b;
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    int                k;
    int                x;
    int                y;
    int                w;
    int                h;
    int unsigned       phase;
    bit                calm;
    bit                vis;
    csob_pkg::shape_e  sh;
    logic [PixelW-1:0] mono_word;

    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state: shape none drops loads, hidden cursor passes pixels through.
    offer_beat(make_beat(csob_pkg::ACT_LOAD, 0, 0, $urandom()));
    offer_beat(make_beat(csob_pkg::ACT_BLEND, 0, 0, 32'hFFFF_FFFF));
    offer_beat(make_beat(csob_pkg::ACT_BLEND, FrameMax, FrameMax, 32'h0000_0000));
    in_if.valid <= 1'b0;

    // Color shape: alpha 255, 0, 1, 2, 254, the far store corner, and loads
    // that fall outside the store.
    setup_cursor(0, 0, 1'b0, csob_pkg::SHAPE_COLOR, 0, 0);
    offer_beat(make_beat(csob_pkg::ACT_LOAD, 0, 0, 32'hFF12_3456));
    offer_beat(make_beat(csob_pkg::ACT_LOAD, 1, 0, 32'h00AB_CDEF));
    offer_beat(make_beat(csob_pkg::ACT_LOAD, 2, 0, 32'h01FF_FFFF));
    offer_beat(make_beat(csob_pkg::ACT_LOAD, 3, 0, 32'h0200_0000));
    offer_beat(make_beat(csob_pkg::ACT_LOAD, 4, 0, 32'hFE00_FF80));
    offer_beat(make_beat(csob_pkg::ACT_LOAD, CursorSize - 1, CursorSize - 1, 32'h80FF_0000));
    offer_beat(make_beat(csob_pkg::ACT_LOAD, CursorSize, 0, $urandom()));
    offer_beat(make_beat(csob_pkg::ACT_LOAD, 0, FrameMax, $urandom()));
    in_if.valid <= 1'b0;

    // Monochrome: all four AND/XOR combinations down column 0.
    settle();
    write_reg(csob_pkg::CFG_SHAPE_TYPE, CfgDataW'(csob_pkg::SHAPE_MONO));
    for (k = 0; k < 4; k++) begin
      mono_word      = $urandom();
      mono_word[1:0] = k[1:0];
      offer_beat(make_beat(csob_pkg::ACT_LOAD, 0, k + 1, mono_word));
    end
    in_if.valid <= 1'b0;

    // Masked color: zero alpha stays clear, any nonzero alpha goes opaque.
    settle();
    write_reg(csob_pkg::CFG_SHAPE_TYPE, CfgDataW'(csob_pkg::SHAPE_MASKED));
    offer_beat(make_beat(csob_pkg::ACT_LOAD, 5, 0, 32'h00FF_FFFF));
    offer_beat(make_beat(csob_pkg::ACT_LOAD, 6, 0, 32'h0112_3456));
    in_if.valid <= 1'b0;

    // Blend over the pixels loaded in row 0 and column 0, plus the first pixel past each edge.
    setup_cursor(0, 0, 1'b1, csob_pkg::SHAPE_MASKED, 7, 5);
    offer_beat(make_beat(csob_pkg::ACT_BLEND, 0, 0, 32'h0000_0000));
    offer_beat(make_beat(csob_pkg::ACT_BLEND, 1, 0, 32'hFFFF_FFFF));
    offer_beat(make_beat(csob_pkg::ACT_BLEND, 2, 0, 32'h0000_0000));
    offer_beat(make_beat(csob_pkg::ACT_BLEND, 3, 0, 32'hFFFF_FFFF));
    offer_beat(make_beat(csob_pkg::ACT_BLEND, 4, 0, 32'h0000_0000));
    offer_beat(make_beat(csob_pkg::ACT_BLEND, 5, 0, 32'hFFFF_FFFF));
    offer_beat(make_beat(csob_pkg::ACT_BLEND, 6, 0, 32'h0000_0000));
    for (k = 1; k <= 4; k++) offer_beat(make_beat(csob_pkg::ACT_BLEND, 0, k, $urandom()));
    offer_beat(make_beat(csob_pkg::ACT_BLEND, 7, 0, $urandom()));
    offer_beat(make_beat(csob_pkg::ACT_BLEND, 0, 5, $urandom()));
    in_if.valid <= 1'b0;

    // Random phases: new cursor setup each time, small sizes mostly, with the
    // odd empty, full-size or oversized cursor and positions at the extremes.
    phase = 0;
    while (tracker.n_blends + tracker.n_stores < ItemTarget) begin
      calm        = (tracker.n_blends + tracker.n_stores >= CalmAfter);
      idle_in_en  = !calm && ($urandom_range(0, 3) != 0);
      idle_out_en = !calm && ($urandom_range(0, 3) != 0);
      sh = csob_pkg::shape_e'($urandom_range(0, 3));
      if (sh == csob_pkg::SHAPE_NONE && $urandom_range(0, 1) == 0) sh = csob_pkg::SHAPE_COLOR;
      case ($urandom_range(0, 9))
        0: begin
          w = int'($urandom_range(0, 1)) * int'($urandom_range(1, 8));
          h = (w == 0) ? int'($urandom_range(0, 8)) : 0;
        end
        1: begin
          w = CursorSize;
          h = CursorSize;
        end
        2: begin
          w = int'($urandom_range(CursorSize + 1, 511));
          h = int'($urandom_range(200, 511));
        end
        default: begin
          w = int'($urandom_range(1, 8));
          h = int'($urandom_range(1, 8));
        end
      endcase
      case ($urandom_range(0, 5))
        0: x = -8192;
        1: x = FrameMax;
        2: x = int'($urandom_range(0, 8)) - 8;
        3: x = FrameMax - int'($urandom_range(0, 8));
        default: x = int'($urandom_range(0, FrameMax));
      endcase
      case ($urandom_range(0, 5))
        0: y = -8192;
        1: y = FrameMax;
        2: y = int'($urandom_range(0, 8)) - 8;
        3: y = FrameMax - int'($urandom_range(0, 8));
        default: y = int'($urandom_range(0, FrameMax));
      endcase
      vis = ($urandom_range(0, 7) != 0);
      setup_cursor(x, y, vis, sh, w, h);
      run_phase($urandom_range(40, 80), phase == 3);
      phase++;
    end

    settle();
    $display("Ran %0d blend beats (%0d changed by the cursor), %0d shape stores and %0d",
             tracker.n_blends, tracker.n_covered, tracker.n_stores, tracker.n_cfg);
    $display("register writes across %0d random cursor setups, all shape types included.",
             phase);
    if (tracker.n_fail == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
